@@ design/assert_macros.svh @@
// Assertion macros shared by the list block's RTL.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OAL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property does not hold");
`define OAL_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define OAL_ASSERT(label, clk, rst, prop)
`define OAL_NEVER(label, clk, rst, cond)
`endif

`endif

@@ design/oal_pkg.sv @@
// Package of the ordered list block: field widths, request and status codes,
// and the result record passed from the sequencer to the output stage.
// No dependencies.
`default_nettype none

package oal_pkg;

  localparam int REQ_W  = 4;
  localparam int POS_W  = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 4;

  localparam int DEPTH_DEFAULT      = 8;
  localparam int WORD_WIDTH_DEFAULT = 32;

  localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int RES_W       = DATA_W + IDX_W + STAT_W + CNT_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SEARCH   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_READ     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] data;
  } result_t;

endpackage

`default_nettype wire

@@ design/oal_cmp.sv @@
// Shared compare unit of the list block: word equality against the request
// key and sign extension of a stored word to the result width. Uses oal_pkg.
`default_nettype none

module oal_cmp #(
  parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic [WORD_WIDTH-1:0]          word,
  input  wire logic [WORD_WIDTH-1:0]          key,
  output logic                                eq,
  output logic signed [oal_pkg::DATA_W-1:0]   word_ext
);
  import oal_pkg::*;

  assign eq       = (word == key);
  assign word_ext = DATA_W'($signed(word));

endmodule

`default_nettype wire

@@ design/oal_core.sv @@
// Sequencer of the list block with the entry memory. Shifts, searches and
// reads go one entry per cycle through a memory with one read and one write
// port and oal_cmp. Uses oal_pkg and oal_cmp.
`default_nettype none

module oal_core #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [oal_pkg::REQ_W-1:0]         in_req,
  input  wire logic [oal_pkg::POS_W-1:0]         in_pos,
  input  wire logic signed [oal_pkg::DATA_W-1:0] in_value,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output oal_pkg::result_t                       res
);
  import oal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHUP   = 3'd1;
  localparam logic [2:0] S_INSWR  = 3'd2;
  localparam logic [2:0] S_SHDN   = 3'd3;
  localparam logic [2:0] S_DELCLR = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]              state;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           ptr;
  logic [AW-1:0]           at_r;
  logic [AW-1:0]           wa;
  logic                    pend;
  logic                    cap;
  logic [WORD_WIDTH-1:0]   key;
  logic signed [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]        idx_r;
  logic [STAT_W-1:0]       stat_r;

  logic [WORD_WIDTH-1:0]   mem [DEPTH];
  logic [WORD_WIDTH-1:0]   rd_data;
  logic                    we;
  logic                    re;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  logic [WORD_WIDTH-1:0]   wdata;

  logic                    acc;
  logic                    is_full;
  logic                    is_empty;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           cnt_ext;
  logic                    ins_pos_ok;
  logic                    del_pos_ok;
  logic [AW-1:0]           at_pos;
  logic [2:0]              dec_state;
  logic [STAT_W-1:0]       dec_stat;
  logic [AW-1:0]           dec_at;
  logic [CW-1:0]           at_ext;
  logic                    up_more;
  logic                    dn_more;
  logic                    eq;
  logic                    match;
  logic signed [DATA_W-1:0] rd_ext;
  logic [AW:0]             idx_full;

  oal_cmp #(.WORD_WIDTH(WORD_WIDTH)) u_cmp (
    .word     (rd_data),
    .key      (key),
    .eq       (eq),
    .word_ext (rd_ext)
  );

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign acc        = in_valid && in_ready;
  assign is_full    = (cnt == CW'(DEPTH));
  assign is_empty   = (cnt == '0);
  assign pos_ext    = PW'(in_pos);
  assign cnt_ext    = PW'(cnt);
  assign ins_pos_ok = (pos_ext >= PW'(1)) && (pos_ext <= cnt_ext + PW'(1));
  assign del_pos_ok = (pos_ext >= PW'(1)) && (pos_ext <= cnt_ext);
  assign at_pos     = AW'(pos_ext - PW'(1));
  assign at_ext     = CW'(at_r);
  assign up_more    = (ptr > at_ext);
  assign dn_more    = (ptr < cnt);
  assign match      = pend && eq;
  assign idx_full   = {1'b0, wa} + (AW + 1)'(1);

  assign res.data   = data_r;
  assign res.index  = idx_r;
  assign res.status = stat_r;
  assign res.count  = CNT_W'(cnt);

  always_comb begin
    dec_state = S_DONE;
    dec_stat  = ST_OK;
    dec_at    = '0;
    unique case (in_req)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (is_full) begin
          dec_stat = ST_FULL;
        end else if (in_req == REQ_INS_POS && !ins_pos_ok) begin
          dec_stat = ST_BADPOS;
        end else begin
          dec_state = S_SHUP;
          if (in_req == REQ_INS_TAIL) begin
            dec_at = AW'(cnt);
          end else if (in_req == REQ_INS_POS) begin
            dec_at = at_pos;
          end
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
        if (is_empty) begin
          dec_stat = ST_EMPTY;
        end else if (in_req == REQ_DEL_POS && !del_pos_ok) begin
          dec_stat = ST_BADPOS;
        end else begin
          dec_state = S_SHDN;
          if (in_req == REQ_DEL_TAIL) begin
            dec_at = AW'(cnt - CW'(1));
          end else if (in_req == REQ_DEL_POS) begin
            dec_at = at_pos;
          end
        end
      end
      REQ_SEARCH: begin
        if (is_empty) begin
          dec_stat = ST_EMPTY;
        end else begin
          dec_state = S_SRCH;
        end
      end
      REQ_READ: begin
        if (is_empty) begin
          dec_stat = ST_EMPTY;
        end else if (!del_pos_ok) begin
          dec_stat = ST_BADPOS;
        end else begin
          dec_state = S_READ;
          dec_at    = at_pos;
        end
      end
      default: begin
        dec_state = S_DONE;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = wa;
    raddr = AW'(ptr);
    wdata = rd_data;
    unique case (state)
      S_IDLE: begin
        if (acc && dec_state == S_READ) begin
          re    = 1'b1;
          raddr = dec_at;
        end
      end
      S_SHUP: begin
        we = pend;
        if (up_more) begin
          re    = 1'b1;
          raddr = AW'(ptr - CW'(1));
        end
      end
      S_INSWR: begin
        we    = 1'b1;
        waddr = at_r;
        wdata = key;
      end
      S_SHDN: begin
        we = pend && !cap;
        re = dn_more;
      end
      S_DELCLR: begin
        we    = 1'b1;
        waddr = AW'(cnt - CW'(1));
        wdata = '0;
      end
      S_SRCH: begin
        re = !match && dn_more;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      cap   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            state  <= dec_state;
            stat_r <= dec_stat;
            data_r <= '0;
            idx_r  <= '0;
            at_r   <= dec_at;
            key    <= WORD_WIDTH'(in_value);
            pend   <= 1'b0;
            cap    <= 1'b1;
            ptr    <= (dec_state == S_SHUP) ? cnt : CW'(dec_at);
            if (in_req == REQ_CLEAR) begin
              cnt <= '0;
            end
          end
        end
        S_SHUP: begin
          if (up_more) begin
            wa   <= AW'(ptr);
            pend <= 1'b1;
            ptr  <= ptr - CW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_INSWR;
          end
        end
        S_INSWR: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_SHDN: begin
          if (pend && cap) begin
            data_r <= rd_ext;
            cap    <= 1'b0;
          end
          if (dn_more) begin
            wa   <= AW'(ptr - CW'(1));
            pend <= 1'b1;
            ptr  <= ptr + CW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_DELCLR;
          end
        end
        S_DELCLR: begin
          cnt   <= cnt - CW'(1);
          state <= S_DONE;
        end
        S_SRCH: begin
          if (match) begin
            idx_r  <= IDX_W'(idx_full);
            pend   <= 1'b0;
            state  <= S_DONE;
          end else if (dn_more) begin
            wa   <= AW'(ptr);
            pend <= 1'b1;
            ptr  <= ptr + CW'(1);
          end else begin
            stat_r <= ST_NOTFOUND;
            pend   <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_READ: begin
          data_r <= rd_ext;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ordered_array_list.sv @@
// Ordered list of signed words, fixed capacity DEPTH, with insert, delete,
// search, read and clear requests. Each request item on the slave stream
// gives exactly one result item on the master stream, in order.
// An item is taken when s_tvalid and s_tready are both high; s_tready is low
// while a request is being worked on. The result then sits in an output
// register until m_tready takes it, and the next request may be accepted
// meanwhile; a further result waits inside until that register is free.
// How long insert, delete and search take is set by the entry memory, with
// one read and one write port, which moves or compares one entry per cycle.
// A new item is taken at the earliest in the cycle after the previous result
// enters the output register.
// Reset empties the list at once; the entry memory needs no clearing pass,
// as only slots below the entry count are ever read.
// Depends on oal_pkg, oal_core, oal_cmp and assert_macros.svh.
`default_nettype none

module ordered_array_list #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // position [3:0], value [35:4], zero fill above
  input  wire logic [oal_pkg::IN_TDATA_W-1:0]     s_tdata,
  // req_type [3:0]
  input  wire logic [oal_pkg::REQ_W-1:0]          s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // data_out [31:0], index_out [35:32], status [38:36], count_out [42:39],
  // zero fill above
  output logic [oal_pkg::OUT_TDATA_W-1:0]         m_tdata
);
  import oal_pkg::*;

  `include "assert_macros.svh"

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_r;

  oal_core #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_pos    (s_tdata[POS_W-1:0]),
    .in_value  (s_tdata[POS_W+DATA_W-1:POS_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = OUT_TDATA_W'(out_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  `OAL_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `OAL_ASSERT(a_empty_has_no_entries, clk, rst, m_tvalid && out_r.status == ST_EMPTY |-> out_r.count == '0)
  `OAL_NEVER(a_status_in_range, clk, rst, m_tvalid && out_r.status > ST_NOTFOUND)

endmodule

`default_nettype wire

@@ verif/list_checker.sv @@
`timescale 1ns / 100ps
// Watches both streams of the ordered list block, keeps its own copy of the
// list, predicts each result item and compares it with what comes out.
// Depends on oal_pkg for field widths, request codes, status codes and result_t.

module list_checker #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = oal_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [oal_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [oal_pkg::REQ_W-1:0]       s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [oal_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              errors,
  output int                              outstanding
);
  import oal_pkg::*;

  logic [63:0] slot_word [DEPTH];
  int          list_len;
  result_t     awaited_results [$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic logic [63:0] word_keep(input logic [63:0] w);
    if (WORD_WIDTH >= 64) return w;
    return w & ((64'd1 << WORD_WIDTH) - 64'd1);
  endfunction

  function automatic logic [DATA_W-1:0] word_widen(input logic [63:0] w);
    logic [63:0] m;
    m = (WORD_WIDTH >= 64) ? '1 : ((64'd1 << WORD_WIDTH) - 64'd1);
    w = w & m;
    if (WORD_WIDTH < 64 && w[WORD_WIDTH-1]) w = w | ~m;
    return w[DATA_W-1:0];
  endfunction

  function automatic result_t list_apply(input logic [REQ_W-1:0] req,
                                         input logic [POS_W-1:0] pos,
                                         input logic [DATA_W-1:0] val);
    result_t     res;
    logic [63:0] key;
    logic [63:0] removed;
    int          at;
    int          p;
    int          k;
    bit          found;
    res   = '0;
    key   = word_keep({{32{val[DATA_W-1]}}, val});
    at    = -1;
    p     = int'(pos);
    found = 0;
    case (req)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (req == REQ_INS_HEAD) at = 0;
          else if (req == REQ_INS_TAIL) at = list_len;
          else if (p >= 1 && p <= list_len + 1) at = p - 1;
          else res.status = ST_BADPOS;
          if (at >= 0) begin
            for (k = list_len; k > at; k--) slot_word[k] = slot_word[k-1];
            slot_word[at] = key;
            list_len++;
          end
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (req == REQ_DEL_HEAD) at = 0;
          else if (req == REQ_DEL_TAIL) at = list_len - 1;
          else if (p >= 1 && p <= list_len) at = p - 1;
          else res.status = ST_BADPOS;
          if (at >= 0) begin
            removed = slot_word[at];
            for (k = at; k + 1 < list_len; k++) slot_word[k] = slot_word[k+1];
            slot_word[list_len-1] = '0;
            list_len--;
            res.data = word_widen(removed);
          end
        end
      end
      REQ_SEARCH: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (k = 0; k < list_len; k++) begin
            if (!found && slot_word[k] == key) begin
              found      = 1;
              res.index  = IDX_W'(k + 1);
              res.status = ST_OK;
            end
          end
        end
      end
      REQ_READ: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (p >= 1 && p <= list_len) res.data = word_widen(slot_word[p-1]);
        else res.status = ST_BADPOS;
      end
      REQ_CLEAR: begin
        for (k = 0; k < DEPTH; k++) slot_word[k] = '0;
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 100)
      $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) slot_word[k] = '0;
      list_len = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.data != want.data)     report_mismatch("data_out", got.data, want.data);
          if (got.index != want.index)   report_mismatch("index_out", got.index, want.index);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.count != want.count)   report_mismatch("count_out", got.count, want.count);
          if (m_tdata[OUT_TDATA_W-1:RES_W] != '0)
            report_mismatch("tdata fill", 64'(m_tdata[OUT_TDATA_W-1:RES_W]), 64'd0);
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(list_apply(s_tuser, s_tdata[POS_W-1:0],
                                             s_tdata[POS_W+DATA_W-1:POS_W]));
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the ordered list testbench: clock, reset, request stimulus with
// bursts and gaps, result back-pressure, and the final verdict.
// Depends on oal_pkg, ordered_array_list and list_checker.

module tb_top;
  import oal_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     err_total;
  int                     outstanding;

  int                     burst_left = 0;
  int                     stall_mode = 0;
  int                     stall_span = 0;
  int                     hold_cnt = 0;
  logic [DATA_W-1:0]      value_pool [8];

  ordered_array_list uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  list_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(err_total), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(50, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (hold_cnt == 0) begin
          m_tready <= ~m_tready;
          hold_cnt <= $urandom_range(1, 20);
        end else begin
          hold_cnt <= hold_cnt - 1;
        end
      end
    endcase
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    logic [IN_TDATA_W-1:0] word;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (s_tvalid) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    word = '0;
    word[POS_W-1:0] = pos;
    word[POS_W+DATA_W-1:POS_W] = val;
    s_tdata  <= word;
    s_tuser  <= req;
    s_tvalid <= 1'b1;
    burst_left--;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [REQ_W-1:0] REQ_REQ_PICK_INS();
    case ($urandom_range(0, 2))
      0: return REQ_INS_HEAD;
      1: return REQ_INS_TAIL;
      default: return REQ_INS_POS;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] REQ_REQ_PICK_DEL();
    case ($urandom_range(0, 2))
      0: return REQ_DEL_HEAD;
      1: return REQ_DEL_TAIL;
      default: return REQ_DEL_POS;
    endcase
  endfunction

  initial begin
    int               roll;
    bit               fill_bias;
    int               phase_left;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(REQ_DEL_HEAD, 4'd1, '0);
    send_request(REQ_SEARCH, 4'd0, 32'h0);
    send_request(REQ_READ, 4'd1, '0);
    send_request(REQ_INS_POS, 4'd2, 32'h1);
    send_request(REQ_INS_HEAD, 4'd0, 32'h7fff_ffff);
    send_request(REQ_INS_TAIL, 4'd0, 32'h8000_0000);
    send_request(REQ_INS_POS, 4'd1, 32'hffff_ffff);
    send_request(REQ_INS_POS, 4'd4, 32'h0);
    send_request(REQ_INS_POS, 4'd0, 32'h5);
    send_request(REQ_INS_POS, 4'd15, 32'h5);
    send_request(REQ_INS_TAIL, 4'd0, 32'hffff_ffff);
    send_request(REQ_INS_HEAD, 4'd0, 32'h1234_5678);
    send_request(REQ_INS_POS, 4'd3, 32'h8000_0000);
    send_request(REQ_INS_TAIL, 4'd0, 32'h5555_aaaa);
    send_request(REQ_INS_HEAD, 4'd0, 32'h1);
    send_request(REQ_SEARCH, 4'd0, 32'hffff_ffff);
    send_request(REQ_SEARCH, 4'd0, 32'h0bad_cafe);
    send_request(REQ_READ, 4'd8, '0);
    send_request(REQ_READ, 4'd9, '0);
    send_request(REQ_DEL_POS, 4'd0, '0);
    send_request(REQ_DEL_POS, 4'd4, '0);
    send_request(REQ_DEL_TAIL, 4'd0, '0);
    send_request(REQ_DEL_HEAD, 4'd0, '0);
    send_request(4'd9, 4'd15, 32'hffff_ffff);
    send_request(4'd15, 4'd0, 32'h0);
    send_request(REQ_CLEAR, 4'd0, '0);

    value_pool[0] = 32'h0;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h7fff_ffff;
    value_pool[3] = 32'h8000_0000;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
    fill_bias  = 1;
    phase_left = $urandom_range(30, 120);

    for (int n = 0; n < 1800; n++) begin
      if (phase_left == 0) begin
        fill_bias  = ~fill_bias;
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < (fill_bias ? 45 : 20))      req = REQ_REQ_PICK_INS();
      else if (roll < 62)                    req = REQ_REQ_PICK_DEL();
      else if (roll < 78)                    req = REQ_SEARCH;
      else if (roll < 95)                    req = REQ_READ;
      else if (roll < 97)                    req = REQ_CLEAR;
      else                                   req = REQ_W'($urandom_range(9, 15));
      pos = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(1, 8))
                                       : POS_W'($urandom_range(0, 15));
      val = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 7)] : $urandom;
      send_request(req, pos, val);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ ordered_array_list.f @@
+incdir+design
design/oal_pkg.sv
design/oal_cmp.sv
design/oal_core.sv
design/ordered_array_list.sv
verif/list_checker.sv
verif/tb_top.sv
